>>> sv/bmg_pkg.sv
`default_nettype none
package bmg_pkg;

  localparam int DimW   = 9;
  localparam int DepthW = 17;
  localparam int MaxDim = 256;

  // (255 * sqrt(3))^2, full-scale sum of squares
  localparam logic [17:0] DepthDiv = 18'd195075;

  typedef enum logic [1:0] {
    TAP_CENTER,
    TAP_X,
    TAP_Y
  } tap_t;

  typedef struct packed {
    logic valid;
    tap_t tap;
  } tap_ctl_t;

  typedef enum logic [2:0] {
    REG_BUMP_ENABLE,
    REG_MAP_WIDTH,
    REG_MAP_HEIGHT,
    REG_INV_SCALE,
    REG_BUMP_RATE
  } cfg_reg_t;

  // eight restoring remainder steps
  function automatic logic [DimW-1:0] mod_step8(input logic [DimW-1:0] rem_in,
                                                input logic [7:0] bits,
                                                input logic [DimW-1:0] dim);
    logic [DimW:0] acc;
    logic [DimW-1:0] r;
    r = rem_in;
    for (int i = 7; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, dim}) begin
        acc = acc - {1'b0, dim};
      end
      r = acc[DimW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d == '0) begin
      r = DimW'(1);
    end else if (32'(d) > 32'(MaxDim)) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/bump_map_gradient_sampler.sv
`default_nettype none
// Channel   Signals                                             Direction
// in        in_valid/in_ready, req_type, texel_index, texel_rgb,  into block
//           coord_x, coord_y
// out       out_valid/out_ready, grad_x, grad_y                  out of block
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data             into block
//
// A texel write is a single access at the texel memory port; a sample reads the
// center, x neighbor and y neighbor in turn from the single-port memory, and the
// front holds off new requests until the y neighbor read. A sample passes through
// scale, remainder, wrap, address, read, depth divide and the 17-stage square
// root. Reset clears control only; the texel memory is undefined until written.
// A stalled output freezes the whole pipeline; in_ready and cfg_ready stay low
// during reset, and cfg_ready is high otherwise.
module bump_map_gradient_sampler #(
  parameter int STORE_DEPTH = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               req_type,
  input  wire logic [15:0]        texel_index,
  input  wire logic [23:0]        texel_rgb,
  input  wire logic signed [23:0] coord_x,
  input  wire logic signed [23:0] coord_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      grad_x,
  output logic signed [16:0]      grad_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef struct packed {
    logic        is_sample;
    logic [15:0] index;
    logic [23:0] rgb;
    logic [23:0] cx;
    logic [23:0] cy;
  } in_t;

  typedef struct packed {
    logic        is_sample;
    logic [15:0] index;
    logic [23:0] rgb;
    logic        nx;
    logic        ny;
    logic [23:0] tx;
    logic [23:0] ty;
    logic [8:0]  rx;
    logic [8:0]  ry;
  } front_t;

  typedef struct packed {
    logic        is_sample;
    logic [15:0] index;
    logic [23:0] rgb;
    logic [8:0]  ix;
    logic [8:0]  iy;
    logic [8:0]  ix1;
    logic [8:0]  iy1;
  } wrap_t;

  typedef struct packed {
    logic        is_sample;
    logic [15:0] index;
    logic [23:0] rgb;
    logic [17:0] a0;
    logic [17:0] ax;
    logic [17:0] ay;
  } addr_t;

  logic        bump_enable;
  logic [8:0]  map_width;
  logic [8:0]  map_height;
  logic [23:0] inv_scale;
  logic [15:0] bump_rate;
  logic [8:0]  dim_w;
  logic [8:0]  dim_h;

  logic   adv;
  logic   front_adv;
  logic   a_valid, b_valid, c_valid, d_valid, e_valid, f_valid, g_valid;
  in_t    a;
  front_t b, c, d, e;
  front_t c_next, d_next, e_next;
  wrap_t  f;
  addr_t  g;
  logic   g_take;

  logic [23:0] mag_x, mag_y;
  logic [47:0] prod_x, prod_y;
  logic [8:0]  ix_w, iy_w;
  logic [9:0]  ix_inc, iy_inc;

  logic [23:0] mem [STORE_DEPTH];
  logic [23:0] rdata;
  logic [17:0] ra;
  logic        oor;
  logic        rd_oor;
  logic        wr_ok;
  bmg_pkg::tap_t     seq;
  bmg_pkg::tap_ctl_t rd_ctl;
  bmg_pkg::tap_ctl_t dctl;
  logic [16:0] depth;
  logic [16:0] dep_c, dep_x;
  logic signed [17:0] dfx, dfy;
  logic signed [16:0] rate_s;
  logic signed [34:0] px, py;

  // configuration
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_enable <= 1'b0;
      map_width   <= 9'd1;
      map_height  <= 9'd1;
      inv_scale   <= 24'd65536;
      bump_rate   <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        bmg_pkg::REG_BUMP_ENABLE: bump_enable <= cfg_data[0];
        bmg_pkg::REG_MAP_WIDTH:   map_width   <= cfg_data[8:0];
        bmg_pkg::REG_MAP_HEIGHT:  map_height  <= cfg_data[8:0];
        bmg_pkg::REG_INV_SCALE:   inv_scale   <= cfg_data;
        bmg_pkg::REG_BUMP_RATE:   bump_rate   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign dim_w = bmg_pkg::clamp_dim(map_width);
  assign dim_h = bmg_pkg::clamp_dim(map_height);

  // flow control
  assign adv       = !out_valid || out_ready;
  assign g_take    = g_valid && (!g.is_sample || seq == bmg_pkg::TAP_Y);
  assign front_adv = adv && (!g_valid || g_take);
  assign in_ready  = front_adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else if (front_adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
    end
  end

  assign mag_x  = a.cx[23] ? (~a.cx + 24'd1) : a.cx;
  assign mag_y  = a.cy[23] ? (~a.cy + 24'd1) : a.cy;
  assign prod_x = 48'(mag_x) * 48'(inv_scale);
  assign prod_y = 48'(mag_y) * 48'(inv_scale);

  // remainder, one byte of the scaled coordinate per stage
  always_comb begin
    c_next    = b;
    c_next.rx = bmg_pkg::mod_step8(b.rx, b.tx[23:16], dim_w);
    c_next.ry = bmg_pkg::mod_step8(b.ry, b.ty[23:16], dim_h);
    d_next    = c;
    d_next.rx = bmg_pkg::mod_step8(c.rx, c.tx[15:8], dim_w);
    d_next.ry = bmg_pkg::mod_step8(c.ry, c.ty[15:8], dim_h);
    e_next    = d;
    e_next.rx = bmg_pkg::mod_step8(d.rx, d.tx[7:0], dim_w);
    e_next.ry = bmg_pkg::mod_step8(d.ry, d.ty[7:0], dim_h);
  end

  // floored wrap: a negative coordinate with nonzero remainder folds back
  assign ix_w   = (e.nx && e.rx != '0) ? dim_w - e.rx : e.rx;
  assign iy_w   = (e.ny && e.ry != '0) ? dim_h - e.ry : e.ry;
  assign ix_inc = {1'b0, ix_w} + 10'd1;
  assign iy_inc = {1'b0, iy_w} + 10'd1;

  always_ff @(posedge clk) begin
    if (front_adv) begin
      a.is_sample <= req_type;
      a.index     <= texel_index;
      a.rgb       <= texel_rgb;
      a.cx        <= coord_x;
      a.cy        <= coord_y;

      b.is_sample <= a.is_sample;
      b.index     <= a.index;
      b.rgb       <= a.rgb;
      b.nx        <= a.cx[23];
      b.ny        <= a.cy[23];
      b.tx        <= prod_x[47:24];
      b.ty        <= prod_y[47:24];
      b.rx        <= '0;
      b.ry        <= '0;

      c <= c_next;
      d <= d_next;
      e <= e_next;

      f.is_sample <= e.is_sample;
      f.index     <= e.index;
      f.rgb       <= e.rgb;
      f.ix        <= ix_w;
      f.iy        <= iy_w;
      f.ix1       <= (ix_inc == {1'b0, dim_w}) ? '0 : ix_inc[8:0];
      f.iy1       <= (iy_inc == {1'b0, dim_h}) ? '0 : iy_inc[8:0];

      g.is_sample <= f.is_sample;
      g.index     <= f.index;
      g.rgb       <= f.rgb;
      g.a0        <= 18'(f.ix) * 18'(dim_h) + 18'(f.iy);
      g.ax        <= 18'(f.ix1) * 18'(dim_h) + 18'(f.iy);
      g.ay        <= 18'(f.ix) * 18'(dim_h) + 18'(f.iy1);
    end
  end

  // texel memory: one access per cycle while the output is not stalled, in item order
  always_comb begin
    case (seq)
      bmg_pkg::TAP_CENTER: ra = g.a0;
      bmg_pkg::TAP_X:      ra = g.ax;
      default:             ra = g.ay;
    endcase
  end

  assign oor   = 32'(ra) >= 32'(STORE_DEPTH);
  assign wr_ok = 32'(g.index) < 32'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (adv && g_valid) begin
      if (!g.is_sample) begin
        if (wr_ok) begin
          mem[AW'(g.index)] <= g.rgb;
        end
      end else begin
        rdata <= mem[AW'(ra)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq    <= bmg_pkg::TAP_CENTER;
      rd_ctl <= '0;
    end else if (adv) begin
      rd_ctl.valid <= g_valid && g.is_sample;
      rd_ctl.tap   <= seq;
      if (g_valid && g.is_sample) begin
        case (seq)
          bmg_pkg::TAP_CENTER: seq <= bmg_pkg::TAP_X;
          bmg_pkg::TAP_X:      seq <= bmg_pkg::TAP_Y;
          default:             seq <= bmg_pkg::TAP_CENTER;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_oor <= oor;
    end
  end

  bmg_depth u_depth (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .texel   (rd_oor ? 24'd0 : rdata),
    .ctl_in  (rd_ctl),
    .depth   (depth),
    .ctl_out (dctl)
  );

  // gather the three depths, emit on the y neighbor
  assign rate_s = signed'({1'b0, bump_rate});
  assign dfx    = signed'({1'b0, dep_x}) - signed'({1'b0, dep_c});
  assign dfy    = signed'({1'b0, depth}) - signed'({1'b0, dep_c});
  assign px     = 35'(dfx) * 35'(rate_s);
  assign py     = 35'(dfy) * 35'(rate_s);

  always_ff @(posedge clk) begin
    if (adv && dctl.valid) begin
      if (dctl.tap == bmg_pkg::TAP_CENTER) begin
        dep_c <= depth;
      end
      if (dctl.tap == bmg_pkg::TAP_X) begin
        dep_x <= depth;
      end
      if (dctl.tap == bmg_pkg::TAP_Y) begin
        grad_x <= bump_enable ? px[32:16] : '0;
        grad_y <= bump_enable ? py[32:16] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dctl.valid && dctl.tap == bmg_pkg::TAP_Y;
    end
  end

  a_hold_front: assert property (@(posedge clk) disable iff (rst)
    g_valid && g.is_sample && seq != bmg_pkg::TAP_Y |-> !in_ready)
    else $error("front advanced during a sample read");

  a_seq_idle: assert property (@(posedge clk) disable iff (rst)
    !g_valid |-> seq == bmg_pkg::TAP_CENTER)
    else $error("read sequencer not at center while memory stage empty");

  a_result: assert property (@(posedge clk) disable iff (rst)
    adv && dctl.valid && dctl.tap == bmg_pkg::TAP_Y |=> out_valid)
    else $error("y depth did not produce a result");

endmodule
`default_nettype wire

>>> sv/bmg_depth.sv
`default_nettype none
module bmg_depth (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [23:0]                 texel,
  input  wire bmg_pkg::tap_ctl_t           ctl_in,
  output logic [bmg_pkg::DepthW-1:0]       depth,
  output bmg_pkg::tap_ctl_t                ctl_out
);

  localparam int NSt = 17;
  localparam logic [33:0] Recip = 34'((64'd1 << 50) / 64'd195075);

  bmg_pkg::tap_ctl_t c1, c2, c3, c4;
  logic [17:0] sq1, sq2, sq3;
  logic [51:0] p2;
  logic [32:0] qe3, q4;
  logic [50:0] pc3;
  logic [32:0] qe_w;
  logic [50:0] rem_w;

  logic [33:0] iv [NSt];
  logic [18:0] ir [NSt];
  logic [16:0] io [NSt];
  bmg_pkg::tap_ctl_t ic [NSt];
  logic [33:0] sv [NSt];
  logic [18:0] sr [NSt];
  logic [16:0] so [NSt];
  bmg_pkg::tap_ctl_t sc [NSt];
  logic [20:0] acc_w [NSt];
  logic [20:0] trial_w [NSt];
  logic [33:0] nv [NSt];
  logic [18:0] nr [NSt];
  logic [16:0] no [NSt];

  assign qe_w  = p2[50:18];
  assign rem_w = {1'b0, sq3, 32'b0} - pc3;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
    end else if (en) begin
      c1 <= ctl_in;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
    end
  end

  // reciprocal multiply, then one correction step
  always_ff @(posedge clk) begin
    if (en) begin
      sq1 <= 18'(texel[7:0]) * 18'(texel[7:0]) + 18'(texel[15:8]) * 18'(texel[15:8])
             + 18'(texel[23:16]) * 18'(texel[23:16]);
      sq2 <= sq1;
      p2  <= 52'(sq1) * 52'(Recip);
      sq3 <= sq2;
      qe3 <= qe_w;
      pc3 <= 51'(qe_w) * 51'(bmg_pkg::DepthDiv);
      q4  <= (rem_w >= 51'(bmg_pkg::DepthDiv)) ? qe3 + 33'd1 : qe3;
    end
  end

  // square root, one result bit per stage
  always_comb begin
    iv[0] = {1'b0, q4};
    ir[0] = '0;
    io[0] = '0;
    ic[0] = c4;
    for (int k = 1; k < NSt; k++) begin
      iv[k] = sv[k-1];
      ir[k] = sr[k-1];
      io[k] = so[k-1];
      ic[k] = sc[k-1];
    end
    for (int k = 0; k < NSt; k++) begin
      acc_w[k]   = {ir[k], iv[k][33:32]};
      trial_w[k] = {2'b0, io[k], 2'b01};
      nv[k]      = {iv[k][31:0], 2'b00};
      if (acc_w[k] >= trial_w[k]) begin
        nr[k] = 19'(acc_w[k] - trial_w[k]);
        no[k] = {io[k][15:0], 1'b1};
      end else begin
        nr[k] = acc_w[k][18:0];
        no[k] = {io[k][15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSt; k++) begin
      if (rst) begin
        sc[k] <= '0;
      end else if (en) begin
        sc[k] <= ic[k];
      end
      if (en) begin
        sv[k] <= nv[k];
        sr[k] <= nr[k];
        so[k] <= no[k];
      end
    end
  end

  assign depth   = so[NSt-1];
  assign ctl_out = sc[NSt-1];

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;
  localparam int   DRAIN_WAIT = 40;
  localparam int   IDLE_LIMIT = 20000;
  localparam int   MAP_SLOTS  = 65536;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    int                 sel;
    logic [23:0]        data;
    logic signed [23:0] x;
    logic signed [23:0] y;
    bit                 typed;
    logic signed [16:0] ex;
    logic signed [16:0] ey;
  } dir_row_t;

  typedef struct {
    logic signed [16:0] gx;
    logic signed [16:0] gy;
  } grad_pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = REQ_WRITE;
  logic [15:0]        texel_index = '0;
  logic [23:0]        texel_rgb = '0;
  logic signed [23:0] coord_x = '0;
  logic signed [23:0] coord_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] grad_x;
  logic signed [16:0] grad_y;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  // predictor state
  logic [23:0] tex_mem [MAP_SLOTS];
  logic        bump_on;
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [23:0] inv_scale_reg;
  logic [15:0] rate_reg;

  grad_pair_t grad_q[$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;

  bump_map_gradient_sampler i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .texel_index(texel_index),
    .texel_rgb  (texel_rgb),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int eff_dim(logic [8:0] d);
    if (d == 0) return 1;
    if (d > 256) return 256;
    return int'(d);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Q1.16 height from color magnitude; white maps to 65536
  function automatic longint texel_depth(logic [23:0] rgb);
    longint unsigned sumsq;
    sumsq = rgb[7:0] * rgb[7:0] + rgb[15:8] * rgb[15:8] + rgb[23:16] * rgb[23:16];
    return longint'(int_sqrt((sumsq << 32) / 64'd195075));
  endfunction

  function automatic int wrap_axis(logic signed [23:0] c, int dim);
    longint cv;
    longint mag;
    longint t;
    longint m;
    cv = c;
    mag = (cv < 0) ? -cv : cv;
    t = (mag * longint'(inv_scale_reg)) >>> 24;
    if (cv < 0) t = -t;
    m = t % dim;
    if (m < 0) m += dim;
    return int'(m);
  endfunction

  // arithmetic shift floors toward minus infinity
  function automatic logic signed [16:0] slope(longint diff);
    longint p;
    p = diff * longint'(rate_reg);
    return 17'(p >>> 16);
  endfunction

  function automatic grad_pair_t predict_grad(logic signed [23:0] x, logic signed [23:0] y);
    grad_pair_t g;
    int w, h, ix, iy;
    longint dc, dx, dy;
    g.gx = '0;
    g.gy = '0;
    if (!bump_on) return g;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    ix = wrap_axis(x, w);
    iy = wrap_axis(y, h);
    dc = texel_depth(tex_mem[ix * h + iy]);
    dx = texel_depth(tex_mem[((ix + 1) % w) * h + iy]);
    dy = texel_depth(tex_mem[ix * h + (iy + 1) % h]);
    g.gx = slope(dx - dc);
    g.gy = slope(dy - dc);
    return g;
  endfunction

  // enter and leave at a falling edge; valid stays high on return
  task automatic send_req(logic rt, logic [15:0] idx, logic [23:0] rgb,
                          logic signed [23:0] x, logic signed [23:0] y,
                          bit typed, logic signed [16:0] ex, logic signed [16:0] ey);
    grad_pair_t g;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    if (rt == REQ_WRITE) begin
      tex_mem[idx] = rgb;
    end else begin
      g = predict_grad(x, y);
      if (typed) begin
        g.gx = ex;
        g.gy = ey;
      end
      grad_q.push_back(g);
    end
    in_valid    <= 1'b1;
    req_type    <= rt;
    texel_index <= idx;
    texel_rgb   <= rgb;
    coord_x     <= x;
    coord_y     <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    while (grad_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  // enter at a falling edge
  task automatic write_reg(bmg_pkg::cfg_reg_t r, logic [23:0] d);
    in_valid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      bmg_pkg::REG_BUMP_ENABLE: bump_on = d[0];
      bmg_pkg::REG_MAP_WIDTH:   width_reg = d[8:0];
      bmg_pkg::REG_MAP_HEIGHT:  height_reg = d[8:0];
      bmg_pkg::REG_INV_SCALE:   inv_scale_reg = d;
      bmg_pkg::REG_BUMP_RATE:   rate_reg = d[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_rgb();
    case ($urandom_range(9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h0000FF << (8 * $urandom_range(2));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic write_texel(logic [15:0] idx);
    send_req(REQ_WRITE, idx, rand_rgb(), 24'($urandom), 24'($urandom), 0, '0, '0);
  endtask

  task automatic sample_rand();
    logic signed [23:0] x, y;
    x = 24'($urandom);
    y = 24'($urandom);
    if ($urandom_range(3) == 0) begin
      x = 24'(int'($urandom_range(600)) - 300);
      y = 24'(int'($urandom_range(600)) - 300);
    end
    send_req(REQ_SAMPLE, 16'($urandom), 24'($urandom), x, y, 0, '0, '0);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    grad_pair_t e;
    if (!rst && out_valid && out_ready) begin
      if (grad_q.size() == 0) begin
        $display("%0t: unexpected result grad_x=%0d grad_y=%0d", $time, grad_x, grad_y);
        errors++;
      end else begin
        e = grad_q.pop_front();
        if (grad_x !== e.gx) begin
          $display("%0t: grad_x expected %0d actual %0d", $time, e.gx, grad_x);
          errors++;
        end
        if (grad_y !== e.gy) begin
          $display("%0t: grad_y expected %0d actual %0d", $time, e.gy, grad_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    int w, h, n;
    bump_on = 1'b0;
    width_reg = 9'd1;
    height_reg = 9'd1;
    inv_scale_reg = 24'd65536;
    rate_reg = 16'd256;

    // 2x2 map: center/corner black, the other two white
    rows = '{
      '{ROW_SAMPLE, 0, 0, 24'sh7FFFFF, -24'sh800000, 1, 0, 0},
      '{ROW_CFG, bmg_pkg::REG_BUMP_ENABLE, 1, 0, 0, 0, 0, 0},
      '{ROW_CFG, bmg_pkg::REG_MAP_WIDTH, 2, 0, 0, 0, 0, 0},
      '{ROW_CFG, bmg_pkg::REG_MAP_HEIGHT, 2, 0, 0, 0, 0, 0},
      '{ROW_CFG, bmg_pkg::REG_BUMP_RATE, 256, 0, 0, 0, 0, 0},
      '{ROW_WRITE, 0, 24'h000000, 0, 0, 0, 0, 0},
      '{ROW_WRITE, 1, 24'hFFFFFF, 0, 0, 0, 0, 0},
      '{ROW_WRITE, 2, 24'hFFFFFF, 0, 0, 0, 0, 0},
      '{ROW_WRITE, 3, 24'h000000, 0, 0, 0, 0, 0},
      '{ROW_SAMPLE, 0, 0, 0, 0, 1, 256, 256},
      '{ROW_SAMPLE, 0, 0, 256, 256, 1, 256, 256},
      '{ROW_SAMPLE, 0, 0, -256, -256, 1, 256, 256},
      '{ROW_SAMPLE, 0, 0, 0, 256, 1, -256, -256},
      '{ROW_CFG, bmg_pkg::REG_BUMP_RATE, 65535, 0, 0, 0, 0, 0},
      '{ROW_SAMPLE, 0, 0, 0, 0, 1, 65535, 65535},
      '{ROW_SAMPLE, 0, 0, 0, 256, 1, -65535, -65535},
      '{ROW_CFG, bmg_pkg::REG_BUMP_RATE, 1, 0, 0, 0, 0, 0},
      '{ROW_SAMPLE, 0, 0, 0, 256, 1, -1, -1},
      '{ROW_WRITE, 2, 24'h0000FF, 0, 0, 0, 0, 0},
      '{ROW_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE, 65535, 24'hFFFFFF, 0, 0, 0, 0, 0},
      '{ROW_CFG, bmg_pkg::REG_INV_SCALE, 24'hFFFFFF, 0, 0, 0, 0, 0},
      '{ROW_SAMPLE, 0, 0, 24'sh7FFFFF, -24'sh800000, 0, 0, 0},
      '{ROW_SAMPLE, 0, 0, -24'sh7FFFFF, 24'sh000181, 0, 0, 0},
      '{ROW_CFG, bmg_pkg::REG_INV_SCALE, 0, 0, 0, 0, 0, 0},
      '{ROW_SAMPLE, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG:   write_reg(bmg_pkg::cfg_reg_t'(rows[i].sel), rows[i].data);
        ROW_WRITE: send_req(REQ_WRITE, 16'(rows[i].sel), rows[i].data, 0, 0, 0, '0, '0);
        default:   send_req(REQ_SAMPLE, 0, 0, rows[i].x, rows[i].y,
                            rows[i].typed, rows[i].ex, rows[i].ey);
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      case (ph)
        0: begin w = 3;   h = 4;   end
        1: begin w = 257; h = 1;   end
        2: begin w = 1;   h = 256; end
        3: begin w = 0;   h = 5;   end
        default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
      endcase
      write_reg(bmg_pkg::REG_BUMP_ENABLE, (ph == 3) ? 24'd0 : 24'd1);
      write_reg(bmg_pkg::REG_MAP_WIDTH, 24'(w));
      write_reg(bmg_pkg::REG_MAP_HEIGHT, 24'(h));
      case (ph)
        0: write_reg(bmg_pkg::REG_INV_SCALE, 24'd65536);
        1: write_reg(bmg_pkg::REG_INV_SCALE, 24'hFFFFFF);
        2: write_reg(bmg_pkg::REG_INV_SCALE, 24'd0);
        default: write_reg(bmg_pkg::REG_INV_SCALE, 24'($urandom));
      endcase
      case (ph)
        1: write_reg(bmg_pkg::REG_BUMP_RATE, 24'd65535);
        2: write_reg(bmg_pkg::REG_BUMP_RATE, 24'd0);
        default: write_reg(bmg_pkg::REG_BUMP_RATE, 24'($urandom));
      endcase
      w = eff_dim(9'(w));
      h = eff_dim(9'(h));
      // fill the whole map so no sample reads an unwritten texel
      for (int a = 0; a < w * h; a++) write_texel(16'(a));
      n = 0;
      while (n < 130) begin
        if (ph == 2 && n == 65) begin
          // hold off until every pending result has returned
          in_valid <= 1'b0;
          drain();
        end
        if ($urandom_range(99) < 75) begin
          sample_rand();
        end else if ($urandom_range(1) == 0) begin
          write_texel(16'($urandom_range(w * h - 1)));
        end else begin
          write_texel(16'($urandom));
        end
        n++;
      end
    end

    in_valid <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
